### hdl/throttled_order_gateway_unit_assert.svh
// Assertion macros for the throttled order gateway.
// Included by the top level; depends on nets named clock and reset in scope.
`ifndef THROTTLED_ORDER_GATEWAY_UNIT_ASSERT_SVH
`define THROTTLED_ORDER_GATEWAY_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define TOGW_ASSERT(lbl, expr) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("togw check failed");
`define TOGW_ASSERT_NEXT(lbl, cause, effect) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cause) |=> (effect)) \
      else $error("togw sequence check failed");
`else
`define TOGW_ASSERT(lbl, expr)
`define TOGW_ASSERT_NEXT(lbl, cause, effect)
`endif
`endif

### hdl/togw_pkg.sv
// Shared types and codes for the throttled order gateway.
// No dependencies.
`default_nettype none
package togw_pkg;
   localparam int QUEUE_DEPTH_DEF = 64;
   localparam int SENT_DEPTH_DEF  = 64;

   localparam logic [2:0] KIND_NEW    = 3'd0;
   localparam logic [2:0] KIND_MODIFY = 3'd1;
   localparam logic [2:0] KIND_CANCEL = 3'd2;
   localparam logic [2:0] KIND_RESP   = 3'd3;
   localparam logic [2:0] KIND_TICK   = 3'd4;

   localparam logic [3:0] EV_SENT     = 4'd0;
   localparam logic [3:0] EV_QUEUED   = 4'd1;
   localparam logic [3:0] EV_REJECTED = 4'd2;
   localparam logic [3:0] EV_FULL     = 4'd3;
   localparam logic [3:0] EV_MODIFIED = 4'd4;
   localparam logic [3:0] EV_CANCELED = 4'd5;
   localparam logic [3:0] EV_LATENCY  = 4'd6;
   localparam logic [3:0] EV_LOGON    = 4'd7;
   localparam logic [3:0] EV_LOGOUT   = 4'd8;
   localparam logic [3:0] EV_NONE     = 4'd9;

   localparam logic [1:0] CSR_LIMIT = 2'd0;
   localparam logic [1:0] CSR_START = 2'd1;
   localparam logic [1:0] CSR_END   = 2'd2;

   typedef struct packed {
      logic [2:0]  kind;
      logic [63:0] order_id;
      logic [31:0] price;
      logic [31:0] qty;
      logic [3:0]  response_type;
      logic [47:0] now_us;
   } req_type;

   typedef struct packed {
      logic [3:0]  event_res;
      logic [63:0] out_order_id;
      logic [31:0] out_price;
      logic [31:0] out_qty;
      logic [3:0]  out_response_type;
      logic [47:0] latency_us;
      logic        last;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_DECODE, ST_QRD, ST_QCMP, ST_QSH_RD, ST_QSH_WR, ST_SRD, ST_SCMP,
      ST_SEND, ST_TRK_RD, ST_TRK_CMP, ST_DRAIN, ST_DRD, ST_FINISH
   } state_type;
endpackage
`default_nettype wire

### hdl/togw_match_unit.sv
// Shared compare unit: id match and saturating latency subtract.
// Depends on nothing but its ports.
`default_nettype none
module togw_match_unit (
   input  wire logic [63:0] key_id,
   input  wire logic [63:0] cand_id,
   input  wire logic [47:0] now_us,
   input  wire logic [47:0] sent_us,
   output logic             hit,
   output logic [47:0]      lat_us
);
   assign hit    = (key_id == cand_id);
   // clamp to zero when the response predates the send
   assign lat_us = (now_us >= sent_us) ? (now_us - sent_us) : 48'd0;
endmodule
`default_nettype wire

### hdl/throttled_order_gateway_unit.sv
// Throttled order gateway top level: sequencer, pending queue, sent table.
// Depends on togw_pkg, togw_match_unit and the assertion macro header.
//
// Usage: drive req_data and raise start while busy is low; the request is
// taken at that edge and busy stays high until its last result is out.
// Results appear one per strobe on rsp_valid/rsp_data; rsp_data.last marks
// the final one of a request. The receiver cannot stall the result side.
// Configuration writes use csr_valid/csr_index/csr_wdata; csr_ready is
// always high; write only while busy is low.
// A send scans the sent table for its id; modify and cancel scan the
// queue one entry at a time, and cancel shifts each later entry forward
// one slot; a response scans the sent table slot by slot. A tick sends
// queued orders one by one, each with a sent table scan. The queue and
// sent table memories are read one entry at a time through the shared
// compare unit. One request is in work at a time.
// Reset (synchronous, active high) empties the queue, clears the sent table
// valid bits, the window count and the session flag, and loads the
// register defaults; no clearing pass is needed.
`default_nettype none
`include "throttled_order_gateway_unit_assert.svh"
module throttled_order_gateway_unit #(
   parameter int QUEUE_DEPTH = togw_pkg::QUEUE_DEPTH_DEF,
   parameter int SENT_DEPTH  = togw_pkg::SENT_DEPTH_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire togw_pkg::req_type req_data,
   output logic                   rsp_valid,
   output togw_pkg::rsp_type      rsp_data,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [1:0]        csr_index,
   input  wire logic [47:0]       csr_wdata
);
   import togw_pkg::*;

   localparam int QA = $clog2(QUEUE_DEPTH);
   localparam int QC = $clog2(QUEUE_DEPTH + 1);
   localparam int SA = $clog2(SENT_DEPTH);
   localparam int SC = $clog2(SENT_DEPTH + 1);

   typedef struct packed {
      logic [63:0] id;
      logic [31:0] price;
      logic [31:0] qty;
   } q_entry_type;

   typedef struct packed {
      logic [63:0] id;
      logic [47:0] sent_us;
   } s_entry_type;

   function automatic logic [QA-1:0] q_inc(input logic [QA-1:0] p);
      logic [QA-1:0] r;
      if (p == QA'(QUEUE_DEPTH - 1)) r = '0;
      else r = p + 1'b1;
      return r;
   endfunction

   function automatic rsp_type mk(input logic [3:0] ev, input logic [63:0] id,
                                  input logic [31:0] pr, input logic [31:0] qt,
                                  input logic [3:0] rt, input logic [47:0] lat);
      rsp_type r;
      r.event_res         = ev;
      r.out_order_id      = id;
      r.out_price         = pr;
      r.out_qty           = qt;
      r.out_response_type = rt;
      r.latency_us        = lat;
      r.last              = 1'b0;
      return r;
   endfunction

   state_type state_ff, state_in;
   req_type   req_ff, req_in;
   logic [5:0]  limit_ff, limit_in;
   logic [47:0] mstart_ff, mstart_in, mend_ff, mend_in;
   logic [5:0]  ws_ff, ws_in;
   logic        open_ff, open_in;

   logic [QA-1:0] q_head_ff, q_head_in, q_tail_ff, q_tail_in, q_ptr_ff, q_ptr_in;
   logic [QC-1:0] q_count_ff, q_count_in, q_pos_ff, q_pos_in;
   q_entry_type   q_mem [QUEUE_DEPTH];
   q_entry_type   q_rd_ff, q_wd;
   logic          q_we;
   logic [QA-1:0] q_wa, q_ra;

   logic [SENT_DEPTH-1:0] s_valid_ff, s_valid_in;
   logic [SC-1:0] s_idx_ff, s_idx_in;
   logic          free_found_ff, free_found_in;
   logic [SA-1:0] free_idx_ff, free_idx_in;
   s_entry_type   s_mem [SENT_DEPTH];
   s_entry_type   s_rd_ff, s_wd;
   logic          s_we;
   logic [SA-1:0] s_wa;

   logic [63:0] sid_ff, sid_in;
   logic [31:0] sprice_ff, sprice_in, sqty_ff, sqty_in;

   logic    hold_v_ff, hold_v_in;
   rsp_type hold_ff, hold_in;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic    prod_v;
   rsp_type prod;

   logic [63:0] key_id, cand_id;
   logic        hit;
   logic [47:0] lat_us;

   logic lt_start, gt_end, lt_end, closed, ws_ok, is_tick;
   logic [SA-1:0] s_addr;

   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign lt_start = (req_ff.now_us < mstart_ff);
   assign gt_end   = (req_ff.now_us > mend_ff);
   assign lt_end   = (req_ff.now_us < mend_ff);
   assign closed   = lt_start || gt_end;
   assign ws_ok    = (ws_ff < limit_ff);
   assign is_tick  = (req_ff.kind == KIND_TICK);
   assign s_addr   = s_idx_ff[SA-1:0];

   assign key_id  = (state_ff == ST_TRK_CMP) ? sid_ff : req_ff.order_id;
   assign cand_id = (state_ff == ST_QCMP) ? q_rd_ff.id : s_rd_ff.id;

   togw_match_unit u_match (
      .key_id  (key_id),
      .cand_id (cand_id),
      .now_us  (req_ff.now_us),
      .sent_us (s_rd_ff.sent_us),
      .hit     (hit),
      .lat_us  (lat_us)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (start) state_in = ST_DECODE;
         ST_DECODE: begin
            if (req_ff.kind <= KIND_CANCEL && closed) state_in = ST_FINISH;
            else begin
               unique case (req_ff.kind)
                  KIND_NEW:    state_in = ws_ok ? ST_SEND : ST_FINISH;
                  KIND_MODIFY: state_in = ST_QRD;
                  KIND_CANCEL: state_in = ST_QRD;
                  KIND_RESP:   state_in = ST_SRD;
                  KIND_TICK:   state_in = ST_DRAIN;
                  default:     state_in = ST_FINISH;
               endcase
            end
         end
         ST_QRD:    state_in = (q_pos_ff == q_count_ff) ? ST_FINISH : ST_QCMP;
         ST_QCMP: begin
            if (hit) state_in = (req_ff.kind == KIND_MODIFY) ? ST_FINISH : ST_QSH_RD;
            else state_in = ST_QRD;
         end
         ST_QSH_RD: state_in = ((q_pos_ff + 1'b1) >= q_count_ff) ? ST_FINISH : ST_QSH_WR;
         ST_QSH_WR: state_in = ST_QSH_RD;
         ST_SRD:    state_in = (s_idx_ff == SC'(SENT_DEPTH)) ? ST_FINISH : ST_SCMP;
         ST_SCMP:   state_in = (hit && s_valid_ff[s_addr]) ? ST_FINISH : ST_SRD;
         ST_SEND:   state_in = ST_TRK_RD;
         ST_TRK_RD: begin
            if (s_idx_ff == SC'(SENT_DEPTH)) state_in = is_tick ? ST_DRAIN : ST_FINISH;
            else state_in = ST_TRK_CMP;
         end
         ST_TRK_CMP: begin
            if (hit && s_valid_ff[s_addr]) state_in = is_tick ? ST_DRAIN : ST_FINISH;
            else state_in = ST_TRK_RD;
         end
         ST_DRAIN:  state_in = (q_count_ff != '0 && ws_ok) ? ST_DRD : ST_FINISH;
         ST_DRD:    state_in = ST_SEND;
         ST_FINISH: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      req_in        = req_ff;
      limit_in      = limit_ff;
      mstart_in     = mstart_ff;
      mend_in       = mend_ff;
      ws_in         = ws_ff;
      open_in       = open_ff;
      q_head_in     = q_head_ff;
      q_tail_in     = q_tail_ff;
      q_ptr_in      = q_ptr_ff;
      q_count_in    = q_count_ff;
      q_pos_in      = q_pos_ff;
      q_we          = 1'b0;
      q_wa          = q_ptr_ff;
      q_wd          = q_rd_ff;
      q_ra          = q_ptr_ff;
      s_valid_in    = s_valid_ff;
      s_idx_in      = s_idx_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      s_we          = 1'b0;
      s_wa          = s_addr;
      s_wd          = '{id: sid_ff, sent_us: req_ff.now_us};
      sid_in        = sid_ff;
      sprice_in     = sprice_ff;
      sqty_in       = sqty_ff;
      hold_v_in     = hold_v_ff;
      hold_in       = hold_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = rsp_ff;
      prod_v        = 1'b0;
      prod          = mk(EV_NONE, 64'd0, 32'd0, 32'd0, 4'd0, 48'd0);

      if (csr_valid) begin
         unique case (csr_index)
            CSR_LIMIT: limit_in  = csr_wdata[5:0];
            CSR_START: mstart_in = csr_wdata;
            CSR_END:   mend_in   = csr_wdata;
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: if (start) req_in = req_data;
         ST_DECODE: begin
            sid_in    = req_ff.order_id;
            sprice_in = req_ff.price;
            sqty_in   = req_ff.qty;
            q_ptr_in  = q_head_ff;
            q_pos_in  = '0;
            s_idx_in  = '0;
            if (req_ff.kind <= KIND_CANCEL && closed) begin
               prod_v = 1'b1;
               prod   = mk(EV_REJECTED, req_ff.order_id, 32'd0, 32'd0, 4'd0, 48'd0);
            end else if (req_ff.kind == KIND_NEW && !ws_ok) begin
               prod_v = 1'b1;
               if (q_count_ff >= QC'(QUEUE_DEPTH)) begin
                  prod = mk(EV_FULL, req_ff.order_id, 32'd0, 32'd0, 4'd0, 48'd0);
               end else begin
                  q_we       = 1'b1;
                  q_wa       = q_tail_ff;
                  q_wd       = '{id: req_ff.order_id, price: req_ff.price, qty: req_ff.qty};
                  q_tail_in  = q_inc(q_tail_ff);
                  q_count_in = q_count_ff + 1'b1;
                  prod = mk(EV_QUEUED, req_ff.order_id, 32'd0, 32'd0, 4'd0, 48'd0);
               end
            end else if (is_tick) begin
               ws_in = '0;
               if (!open_ff && !lt_start && lt_end) begin
                  prod_v  = 1'b1;
                  prod    = mk(EV_LOGON, 64'd0, 32'd0, 32'd0, 4'd0, 48'd0);
                  open_in = 1'b1;
               end else if (open_ff && !lt_end) begin
                  prod_v  = 1'b1;
                  prod    = mk(EV_LOGOUT, 64'd0, 32'd0, 32'd0, 4'd0, 48'd0);
                  open_in = 1'b0;
               end
            end
         end
         ST_QRD: q_ra = q_ptr_ff;
         ST_QCMP: begin
            if (hit) begin
               prod_v = 1'b1;
               if (req_ff.kind == KIND_MODIFY) begin
                  q_we = 1'b1;
                  q_wa = q_ptr_ff;
                  q_wd = '{id: q_rd_ff.id, price: req_ff.price, qty: req_ff.qty};
                  prod = mk(EV_MODIFIED, req_ff.order_id, 32'd0, 32'd0, 4'd0, 48'd0);
               end else begin
                  prod = mk(EV_CANCELED, req_ff.order_id, 32'd0, 32'd0, 4'd0, 48'd0);
               end
            end else begin
               q_ptr_in = q_inc(q_ptr_ff);
               q_pos_in = q_pos_ff + 1'b1;
            end
         end
         ST_QSH_RD: begin
            q_ra = q_inc(q_ptr_ff);
            // last slot freed: it becomes the new tail
            if ((q_pos_ff + 1'b1) >= q_count_ff) begin
               q_count_in = q_count_ff - 1'b1;
               q_tail_in  = q_ptr_ff;
            end
         end
         ST_QSH_WR: begin
            q_we     = 1'b1;
            q_wa     = q_ptr_ff;
            q_wd     = q_rd_ff;
            q_ptr_in = q_inc(q_ptr_ff);
            q_pos_in = q_pos_ff + 1'b1;
         end
         ST_SRD: ;
         ST_SCMP: begin
            if (hit && s_valid_ff[s_addr]) begin
               s_valid_in[s_addr] = 1'b0;
               prod_v = 1'b1;
               prod   = mk(EV_LATENCY, req_ff.order_id, 32'd0, 32'd0,
                           req_ff.response_type, lat_us);
            end else begin
               s_idx_in = s_idx_ff + 1'b1;
            end
         end
         ST_SEND: begin
            prod_v        = 1'b1;
            prod          = mk(EV_SENT, sid_ff, sprice_ff, sqty_ff, 4'd0, 48'd0);
            ws_in         = ws_ff + 1'b1;
            s_idx_in      = '0;
            free_found_in = 1'b0;
         end
         ST_TRK_RD: begin
            // end of scan with no match: take the first free slot
            if (s_idx_ff == SC'(SENT_DEPTH) && free_found_ff) begin
               s_we = 1'b1;
               s_wa = free_idx_ff;
               s_valid_in[free_idx_ff] = 1'b1;
            end
         end
         ST_TRK_CMP: begin
            if (hit && s_valid_ff[s_addr]) begin
               s_we = 1'b1;
               s_wa = s_addr;
            end else begin
               if (!s_valid_ff[s_addr] && !free_found_ff) begin
                  free_found_in = 1'b1;
                  free_idx_in   = s_addr;
               end
               s_idx_in = s_idx_ff + 1'b1;
            end
         end
         ST_DRAIN: q_ra = q_head_ff;
         ST_DRD: begin
            sid_in     = q_rd_ff.id;
            sprice_in  = q_rd_ff.price;
            sqty_in    = q_rd_ff.qty;
            q_head_in  = q_inc(q_head_ff);
            q_count_in = q_count_ff - 1'b1;
         end
         ST_FINISH: begin
            rsp_valid_in = 1'b1;
            rsp_in       = hold_v_ff ? hold_ff
                                     : mk(EV_NONE, 64'd0, 32'd0, 32'd0, 4'd0, 48'd0);
            rsp_in.last  = 1'b1;
            hold_v_in    = 1'b0;
         end
         default: ;
      endcase

      // hold each result one step so the final one can carry last
      if (prod_v) begin
         if (hold_v_ff) begin
            rsp_valid_in = 1'b1;
            rsp_in       = hold_ff;
            rsp_in.last  = 1'b0;
         end
         hold_v_in = 1'b1;
         hold_in   = prod;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         limit_ff      <= 6'd10;
         mstart_ff     <= '0;
         mend_ff       <= '0;
         ws_ff         <= '0;
         open_ff       <= 1'b0;
         q_head_ff     <= '0;
         q_tail_ff     <= '0;
         q_count_ff    <= '0;
         s_valid_ff    <= '0;
         free_found_ff <= 1'b0;
         hold_v_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         limit_ff      <= limit_in;
         mstart_ff     <= mstart_in;
         mend_ff       <= mend_in;
         ws_ff         <= ws_in;
         open_ff       <= open_in;
         q_head_ff     <= q_head_in;
         q_tail_ff     <= q_tail_in;
         q_count_ff    <= q_count_in;
         s_valid_ff    <= s_valid_in;
         free_found_ff <= free_found_in;
         hold_v_ff     <= hold_v_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      req_ff      <= req_in;
      q_ptr_ff    <= q_ptr_in;
      q_pos_ff    <= q_pos_in;
      s_idx_ff    <= s_idx_in;
      free_idx_ff <= free_idx_in;
      sid_ff      <= sid_in;
      sprice_ff   <= sprice_in;
      sqty_ff     <= sqty_in;
      hold_ff     <= hold_in;
      rsp_ff      <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (q_we) q_mem[q_wa] <= q_wd;
      q_rd_ff <= q_mem[q_ra];
   end

   always_ff @(posedge clock) begin
      if (s_we) s_mem[s_wa] <= s_wd;
      s_rd_ff <= s_mem[s_addr];
   end

   `TOGW_ASSERT(a_count_bound, q_count_ff <= QC'(QUEUE_DEPTH))
   `TOGW_ASSERT(a_last_ends_busy, !(rsp_valid && rsp_data.last) || !busy)
   `TOGW_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
endmodule
`default_nettype wire

### tb/sv/tb_throttled_order_gateway_unit.sv
`timescale 1ns / 100ps
// Testbench for throttled_order_gateway_unit: directed table, then random phases.
// Every taken request is checked against a behavioral gateway model kept here.
// Depends on togw_pkg and the gateway RTL.
module tb_throttled_order_gateway_unit;
   import togw_pkg::*;

   localparam int  Q_DEPTH    = 64;
   localparam int  S_DEPTH    = 64;
   localparam int  CYCLE_MAX  = 20000000;
   localparam logic [47:0] T_MAX = 48'hFFFF_FFFF_FFFF;

   typedef struct {
      bit [63:0] id;
      bit [31:0] price;
      bit [31:0] qty;
   } pend_entry_t;

   typedef struct {
      bit          is_csr;
      logic [1:0]  csr_sel;
      logic [47:0] csr_val;
      req_type     order;
      bit          typed;
      logic [3:0]  ev;
   } script_row_t;

   logic    clock, reset, start, busy, rsp_valid, csr_valid, csr_ready;
   req_type req_data;
   rsp_type rsp_data;
   logic [1:0]  csr_index;
   logic [47:0] csr_wdata;

   // gateway model state
   bit [5:0]  m_limit;
   bit [47:0] m_start, m_end;
   bit [5:0]  m_window_sent;
   bit        m_open;
   pend_entry_t m_pending[$];
   bit        m_sent_valid[S_DEPTH];
   bit [63:0] m_sent_id[S_DEPTH];
   bit [47:0] m_sent_time[S_DEPTH];

   rsp_type   pending_events[$];
   script_row_t script[$];
   int        n_errors, n_items, n_results, n_ticks, n_full, cycles;
   bit        no_idle;

   throttled_order_gateway_unit u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic void post_event(logic [3:0] ev, logic [63:0] id, logic [31:0] price,
                                      logic [31:0] qty, logic [3:0] rt, logic [47:0] lat);
      rsp_type r;
      r.event_res = ev;
      r.out_order_id = id;
      r.out_price = price;
      r.out_qty = qty;
      r.out_response_type = rt;
      r.latency_us = lat;
      r.last = 1'b0;
      pending_events.push_back(r);
      if (ev == EV_FULL) n_full++;
   endfunction

   function automatic void release_order(bit [63:0] id, bit [31:0] price, bit [31:0] qty,
                                         bit [47:0] now);
      int slot;
      slot = -1;
      post_event(EV_SENT, id, price, qty, 4'd0, 48'd0);
      for (int i = 0; i < S_DEPTH; i++)
         if (slot < 0 && m_sent_valid[i] && m_sent_id[i] == id) slot = i;
      for (int i = 0; i < S_DEPTH; i++)
         if (slot < 0 && !m_sent_valid[i]) slot = i;
      // table full: send untracked
      if (slot >= 0) begin
         m_sent_valid[slot] = 1'b1;
         m_sent_id[slot] = id;
         m_sent_time[slot] = now;
      end
      m_window_sent = m_window_sent + 6'd1;
   endfunction

   function automatic void predict_gateway(req_type r);
      int base, pos;
      pend_entry_t e;
      base = pending_events.size();
      pos = -1;
      if (r.kind <= KIND_CANCEL) begin
         if (r.now_us < m_start || r.now_us > m_end) begin
            post_event(EV_REJECTED, r.order_id, 0, 0, 0, 0);
         end else if (r.kind == KIND_NEW) begin
            if (m_window_sent < m_limit) begin
               release_order(r.order_id, r.price, r.qty, r.now_us);
            end else if (m_pending.size() >= Q_DEPTH) begin
               post_event(EV_FULL, r.order_id, 0, 0, 0, 0);
            end else begin
               e.id = r.order_id;
               e.price = r.price;
               e.qty = r.qty;
               m_pending.push_back(e);
               post_event(EV_QUEUED, r.order_id, 0, 0, 0, 0);
            end
         end else begin
            // oldest matching entry wins
            for (int i = 0; i < m_pending.size(); i++)
               if (pos < 0 && m_pending[i].id == r.order_id) pos = i;
            if (pos < 0) begin
               post_event(EV_NONE, 0, 0, 0, 0, 0);
            end else if (r.kind == KIND_MODIFY) begin
               m_pending[pos].price = r.price;
               m_pending[pos].qty = r.qty;
               post_event(EV_MODIFIED, r.order_id, 0, 0, 0, 0);
            end else begin
               m_pending.delete(pos);
               post_event(EV_CANCELED, r.order_id, 0, 0, 0, 0);
            end
         end
      end else if (r.kind == KIND_RESP) begin
         for (int i = 0; i < S_DEPTH; i++)
            if (pos < 0 && m_sent_valid[i] && m_sent_id[i] == r.order_id) pos = i;
         if (pos >= 0) begin
            m_sent_valid[pos] = 1'b0;
            post_event(EV_LATENCY, r.order_id, 0, 0, r.response_type,
                       (r.now_us >= m_sent_time[pos]) ? r.now_us - m_sent_time[pos] : 48'd0);
         end else begin
            post_event(EV_NONE, 0, 0, 0, 0, 0);
         end
      end else if (r.kind == KIND_TICK) begin
         n_ticks++;
         if (!m_open && r.now_us >= m_start && r.now_us < m_end) begin
            post_event(EV_LOGON, 0, 0, 0, 0, 0);
            m_open = 1'b1;
         end else if (m_open && r.now_us >= m_end) begin
            post_event(EV_LOGOUT, 0, 0, 0, 0, 0);
            m_open = 1'b0;
         end
         m_window_sent = 6'd0;
         while (m_pending.size() > 0 && m_window_sent < m_limit) begin
            e = m_pending.pop_front();
            release_order(e.id, e.price, e.qty, r.now_us);
         end
         if (pending_events.size() == base) post_event(EV_NONE, 0, 0, 0, 0, 0);
      end else begin
         post_event(EV_NONE, 0, 0, 0, 0, 0);
      end
      pending_events[pending_events.size() - 1].last = 1'b1;
   endfunction

   // compare each result against the oldest outstanding event
   always @(posedge clock) begin
      rsp_type want;
      cycles <= cycles + 1;
      if (cycles > CYCLE_MAX) begin
         $display("timeout after %0d cycles", cycles);
         $display("throttled_order_gateway_unit verification failed");
         $finish;
      end
      if (!reset && rsp_valid) begin
         n_results++;
         if (pending_events.size() == 0) begin
            n_errors++;
            if (n_errors <= 10) $display("unexpected result %p", rsp_data);
         end else begin
            want = pending_events.pop_front();
            if (rsp_data.event_res !== want.event_res ||
                rsp_data.out_order_id !== want.out_order_id ||
                rsp_data.out_price !== want.out_price ||
                rsp_data.out_qty !== want.out_qty ||
                rsp_data.out_response_type !== want.out_response_type ||
                rsp_data.latency_us !== want.latency_us ||
                rsp_data.last !== want.last) begin
               n_errors++;
               if (n_errors <= 10)
                  $display("mismatch at cycle %0d: expected %p got %p", cycles, want, rsp_data);
            end
         end
      end
   end

   task automatic issue_request(req_type r, bit typed, logic [3:0] ev);
      int gap, base;
      gap = no_idle ? 0 : ($urandom_range(0, 1) ? $urandom_range(0, 16) : 0);
      repeat (gap) @(negedge clock);
      req_data = r;
      start = 1'b1;
      do @(posedge clock); while (busy);
      base = pending_events.size();
      predict_gateway(r);
      n_items++;
      if (typed && pending_events[base].event_res != ev) begin
         n_errors++;
         if (n_errors <= 10) $display("request %0d: model gives event %0d, table says %0d",
                                      n_items, pending_events[base].event_res, ev);
      end
      @(negedge clock);
      start = 1'b0;
   endtask

   // hold until every outstanding result is back and the block is quiet
   task automatic wait_drained();
      do @(posedge clock); while (pending_events.size() != 0 || busy);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(logic [1:0] sel, logic [47:0] val);
      wait_drained();
      csr_index = sel;
      csr_wdata = val;
      csr_valid = 1'b1;
      do @(posedge clock); while (!csr_ready);
      case (sel)
         CSR_LIMIT: m_limit = val[5:0];
         CSR_START: m_start = val;
         CSR_END:   m_end = val;
         default: ;
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   function automatic void add_row(logic [2:0] kind, logic [63:0] id, logic [31:0] price,
                                   logic [31:0] qty, logic [3:0] rt, logic [47:0] now,
                                   bit typed, logic [3:0] ev);
      script_row_t s;
      s.is_csr = 1'b0;
      s.csr_sel = CSR_LIMIT;
      s.csr_val = 48'd0;
      s.order = '{kind, id, price, qty, rt, now};
      s.typed = typed;
      s.ev = ev;
      script.push_back(s);
   endfunction

   function automatic void add_csr(logic [1:0] sel, logic [47:0] val);
      script_row_t s;
      s = '{1'b1, sel, val, '0, 1'b0, EV_NONE};
      script.push_back(s);
   endfunction

   function automatic logic [47:0] pick_time();
      logic [63:0] span, t;
      t = {$urandom, $urandom};
      if ($urandom_range(0, 9) < 2 || m_start > m_end) return t[47:0];
      if ($urandom_range(0, 9) == 0) return $urandom_range(0, 1) ? m_start : m_end;
      span = {16'd0, m_end} - {16'd0, m_start} + 64'd1;
      t = t % span;
      return m_start + t[47:0];
   endfunction

   task automatic run_phase(int count, int pct_new, int pct_tick, bit pause_midway);
      req_type r;
      int roll;
      for (int n = 0; n < count; n++) begin
         if (pause_midway && n == count / 2) wait_drained();
         roll = $urandom_range(0, 99);
         if (roll < pct_new) r.kind = KIND_NEW;
         else if (roll < pct_new + pct_tick) r.kind = KIND_TICK;
         else if (roll >= 97) r.kind = 3'($urandom_range(5, 7));
         else r.kind = 3'($urandom_range(KIND_MODIFY, KIND_RESP));
         r.order_id = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom}
                                                   : 64'($urandom_range(1, 24));
         r.price = $urandom;
         r.qty = $urandom;
         r.response_type = 4'($urandom);
         r.now_us = pick_time();
         issue_request(r, 1'b0, EV_NONE);
      end
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = CSR_LIMIT;
      csr_wdata = '0;
      cycles = 0;
      no_idle = 1'b0;
      m_limit = 6'd10;
      m_start = 48'd0;
      m_end = 48'd0;
      m_window_sent = 6'd0;
      m_open = 1'b0;
      for (int i = 0; i < S_DEPTH; i++) m_sent_valid[i] = 1'b0;

      // reset values: limit 10, window [0,0]
      add_row(KIND_NEW, 64'd1, 32'hFFFF_FFFF, 32'd0, 4'd0, 48'd0, 1, EV_SENT);
      add_row(KIND_NEW, '1, 32'd0, 32'hFFFF_FFFF, 4'hF, 48'd0, 1, EV_SENT);
      add_row(KIND_NEW, 64'd2, 32'd3, 32'd4, 4'd0, 48'd1, 1, EV_REJECTED);
      add_row(KIND_MODIFY, 64'd5, 32'd1, 32'd1, 4'd0, 48'd0, 1, EV_NONE);
      add_row(KIND_CANCEL, 64'd5, 32'd0, 32'd0, 4'd0, 48'd0, 1, EV_NONE);
      add_row(KIND_RESP, 64'd1, 32'd0, 32'd0, 4'hF, 48'd7, 1, EV_LATENCY);
      add_row(KIND_RESP, 64'd1, 32'd0, 32'd0, 4'd2, 48'd9, 1, EV_NONE);
      add_row(KIND_TICK, 64'd0, 32'd0, 32'd0, 4'd0, 48'd0, 1, EV_NONE);
      add_row(3'd5, 64'd1, 32'd1, 32'd1, 4'd1, 48'd0, 1, EV_NONE);
      add_row(3'd7, '1, '1, '1, 4'hF, T_MAX, 1, EV_NONE);
      add_csr(CSR_LIMIT, 48'd2);
      add_csr(CSR_START, 48'd100);
      add_csr(CSR_END, 48'd1000);
      add_row(KIND_TICK, 64'd0, 32'd0, 32'd0, 4'd0, 48'd100, 1, EV_LOGON);
      add_row(KIND_NEW, 64'd10, 32'd11, 32'd12, 4'd0, 48'd200, 0, EV_NONE);
      add_row(KIND_NEW, 64'd11, 32'd13, 32'd14, 4'd0, 48'd300, 0, EV_NONE);
      add_row(KIND_NEW, 64'd12, 32'd5, 32'd5, 4'd0, 48'd400, 1, EV_QUEUED);
      add_row(KIND_NEW, 64'd12, 32'd6, 32'd6, 4'd0, 48'd400, 1, EV_QUEUED);
      add_row(KIND_MODIFY, 64'd12, 32'd77, 32'd88, 4'd0, 48'd500, 1, EV_MODIFIED);
      add_row(KIND_CANCEL, 64'd12, 32'd0, 32'd0, 4'd0, 48'd500, 1, EV_CANCELED);
      add_row(KIND_RESP, 64'd10, 32'd0, 32'd0, 4'd6, 48'd150, 0, EV_NONE);
      add_row(KIND_NEW, 64'd13, 32'd1, 32'd1, 4'd0, 48'd99, 1, EV_REJECTED);
      add_row(KIND_NEW, 64'd13, 32'd1, 32'd1, 4'd0, 48'd1001, 1, EV_REJECTED);
      add_row(KIND_TICK, 64'd0, 32'd0, 32'd0, 4'd0, 48'd1000, 1, EV_LOGOUT);

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (script[i]) begin
         if (script[i].is_csr) write_csr(script[i].csr_sel, script[i].csr_val);
         else issue_request(script[i].order, script[i].typed, script[i].ev);
      end

      // full time range, limit of 62
      write_csr(CSR_START, 48'd0);
      write_csr(CSR_END, T_MAX);
      write_csr(CSR_LIMIT, 48'd62);
      run_phase(90, 40, 8, 1);
      // throttle shut: fill the queue past full, ticks drain nothing
      write_csr(CSR_LIMIT, 48'd0);
      write_csr(CSR_START, 48'd1000);
      write_csr(CSR_END, 48'd5000);
      no_idle = 1'b1;
      run_phase(80, 92, 2, 0);
      no_idle = 1'b0;
      // reopen and drain up to 62 queued orders in one tick
      write_csr(CSR_LIMIT, 48'd62);
      issue_request('{KIND_TICK, 64'd0, 32'd0, 32'd0, 4'd0, 48'd2000}, 1'b0, EV_NONE);
      run_phase(60, 35, 10, 0);
      // lower the limit below what was already sent this window
      write_csr(CSR_LIMIT, 48'd1);
      run_phase(50, 50, 6, 0);
      // start after end: every new, modify and cancel is rejected
      write_csr(CSR_START, 48'd6000);
      write_csr(CSR_END, 48'd4000);
      run_phase(25, 40, 10, 0);
      // window at the top of the time range
      write_csr(CSR_START, T_MAX - 48'd5000);
      write_csr(CSR_END, T_MAX);
      write_csr(CSR_LIMIT, 48'd3);
      run_phase(60, 40, 12, 0);

      wait_drained();
      repeat (2 * S_DEPTH + 10) @(posedge clock);
      $display("%0d requests (%0d ticks) produced %0d results, %0d queue-full rejects",
               n_items, n_ticks, n_results, n_full);
      if (n_errors == 0 && pending_events.size() == 0) begin
         $display("throttled_order_gateway_unit verification clean");
      end else begin
         $display("%0d mismatches, %0d results missing", n_errors, pending_events.size());
         $display("throttled_order_gateway_unit verification failed");
      end
      $finish;
   end
endmodule
